// ===== design/mht_pkg.sv =====
// shared types, byte codes and character classes for the mail header tokenizer
// no dependencies; used by mht_step, mht_outbuf and mail_header_tokenizer_top
package mht_pkg;

    // result kinds
    localparam logic [2:0] K_TEXT     = 3'd0;
    localparam logic [2:0] K_ATOM_END = 3'd1;
    localparam logic [2:0] K_QSTR_END = 3'd2;
    localparam logic [2:0] K_SPECIAL  = 3'd3;
    localparam logic [2:0] K_ERROR    = 3'd4;
    localparam logic [2:0] K_END      = 3'd5;

    // scan modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ATOM = 2'd1;
    localparam logic [1:0] MODE_QSTR = 2'd2;

    // configuration register indexes
    localparam logic CFG_DOT   = 1'b0;
    localparam logic CFG_EQUAL = 1'b1;

    // byte codes
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_EQUAL = 8'h3d;

    // result list size; one byte causes at most three results
    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [1:0] mode;
        logic       esc;     // escape pending inside a comment
        logic       qp;      // quoted pair pending
        logic       cr;      // carriage return held
    } scan_state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       final_res;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] ent;
        logic [2:0]         cnt;
    } res_list_t;

    // space, tab, lf, vt, ff, cr
    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
    endfunction

    // ( ) < > [ ] : ; @ \ , nul, plus optional dot and equals
    function automatic logic special_char(input logic [7:0] c, input logic dot,
                                          input logic eq);
        if (c inside {8'h00, 8'h28, 8'h29, 8'h3c, 8'h3e, 8'h5b, 8'h5d,
                      8'h3a, 8'h3b, 8'h40, 8'h5c, 8'h2c}) begin
            return 1'b1;
        end
        if (c == CH_DOT) begin
            return dot;
        end
        if (c == CH_EQUAL) begin
            return eq;
        end
        return 1'b0;
    endfunction

endpackage

// ===== design/mail_header_tokenizer_top.sv =====
// Mail header tokenizer: byte-stream scanner for header text.
// Input channel (s_): one header byte per beat with an end-of-buffer flag.
// Output channel (m_): one result per beat: kind, value and a final flag on
// the last result of a buffer. Config port: cfg_we with cfg_index 0 sets
// dot-is-special, index 1 sets equals-is-special; write only when idle.
// Path: a byte accepted on s_ is held in the input register, scanned
// combinationally out of it, and its results are loaded into the result
// register that drives m_.
// Throughput: one byte per cycle while each byte gives at most one result
// and m_ready stays high; a byte that gives more than one result keeps the
// next result-giving byte waiting until the result register, with its single
// output beat per cycle, has handed all of its results out. Bytes giving no result are scanned even while it is busy.
// Reset (aresetn low, synchronous): scan state, comment depth, config and
// both channel registers clear. When the receiver stalls, the result
// register holds, then the input register fills and s_ready drops.
// depends on mht_pkg, mht_step, mht_outbuf
module mail_header_tokenizer_top #(
    parameter int MAX_COMMENT_DEPTH = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_buffer,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_value,
    output logic       m_final_res,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic       cfg_data
);

    localparam int LVL_W = $clog2(MAX_COMMENT_DEPTH + 1);

    logic                 dot_reg;
    logic                 eq_reg;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    mht_pkg::scan_state_t st_reg;
    mht_pkg::scan_state_t st_next;
    logic [LVL_W-1:0]     lvl_reg;
    logic [LVL_W-1:0]     lvl_next;
    mht_pkg::res_list_t   rlist;
    logic                 ob_free;
    logic                 consume;
    logic                 load;

    // scan the held byte once the result register can take its results
    assign consume = in_valid_reg && (rlist.cnt == 3'd0 || ob_free);
    assign load    = consume && rlist.cnt != 3'd0;
    assign s_ready = !in_valid_reg || consume;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= 1'b0;
            eq_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                mht_pkg::CFG_DOT:   dot_reg <= cfg_data;
                mht_pkg::CFG_EQUAL: eq_reg  <= cfg_data;
                default:            dot_reg <= dot_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_end_of_buffer;
        end
    end

    // scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= '0;
            lvl_reg <= '0;
        end else if (consume) begin
            st_reg  <= st_next;
            lvl_reg <= lvl_next;
        end
    end

    mht_step #(
        .MAX_DEPTH (MAX_COMMENT_DEPTH)
    ) u_step (
        .in_byte     (in_byte_reg),
        .last        (in_last_reg),
        .dot_special (dot_reg),
        .eq_special  (eq_reg),
        .st          (st_reg),
        .lvl         (lvl_reg),
        .st_next     (st_next),
        .lvl_next    (lvl_next),
        .rlist       (rlist)
    );

    mht_outbuf u_outbuf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .rlist       (rlist),
        .free        (ob_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_value     (m_value),
        .m_final_res (m_final_res)
    );

    // comment depth stays within its limit
    a_depth_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        lvl_reg <= LVL_W'(MAX_COMMENT_DEPTH))
        else $error("comment depth above limit");

    // a held cr only exists inside a quoted string
    a_cr_in_qstr: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.cr |-> st_reg.mode == mht_pkg::MODE_QSTR)
        else $error("cr held outside quoted string");

    // scanning the last byte of a buffer returns the scanner to rest
    a_buffer_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_last_reg) |=> (st_reg == '0 && lvl_reg == '0))
        else $error("state not cleared at buffer end");

endmodule

// ===== design/mht_step.sv =====
// combinational scan of one header byte: next state and the list of results
// depends on mht_pkg
module mht_step #(
    parameter int MAX_DEPTH = 255,
    localparam int LVL_W = $clog2(MAX_DEPTH + 1)
) (
    input  logic [7:0]                in_byte,
    input  logic                      last,
    input  logic                      dot_special,
    input  logic                      eq_special,
    input  mht_pkg::scan_state_t      st,
    input  logic [LVL_W-1:0]          lvl,
    output mht_pkg::scan_state_t      st_next,
    output logic [LVL_W-1:0]          lvl_next,
    output mht_pkg::res_list_t        rlist
);

    typedef struct packed {
        logic       emit;
        logic [2:0] kind;
        logic [7:0] value;
        logic       qp;
        logic       close;
    } plain_t;

    // append one result, dropping anything past the list size
    function automatic mht_pkg::res_list_t push(input mht_pkg::res_list_t l,
                                                input logic [2:0] kind,
                                                input logic [7:0] value);
        mht_pkg::res_list_t r;
        r = l;
        if (r.cnt < 3'(mht_pkg::MAX_RES)) begin
            r.ent[r.cnt[1:0]].kind      = kind;
            r.ent[r.cnt[1:0]].value     = value;
            r.ent[r.cnt[1:0]].final_res = 1'b0;
            r.cnt = r.cnt + 3'd1;
        end
        return r;
    endfunction

    // ordinary byte inside a quoted string
    function automatic plain_t qstr_plain(input logic [7:0] c, input logic qp);
        plain_t p;
        p = '0;
        if (qp) begin
            p.emit  = 1'b1;
            p.kind  = mht_pkg::K_TEXT;
            p.value = c;
        end else if (c == mht_pkg::CH_BSL) begin
            p.qp = 1'b1;
        end else if (c == mht_pkg::CH_DQUOT) begin
            p.emit  = 1'b1;
            p.kind  = mht_pkg::K_QSTR_END;
            p.close = 1'b1;
        end else begin
            p.emit  = 1'b1;
            p.kind  = mht_pkg::K_TEXT;
            p.value = c;
        end
        return p;
    endfunction

    logic   term;
    logic   do_idle;
    logic   done;
    logic   [1:0] fidx;
    plain_t pr;

    always_comb begin
        st_next  = st;
        lvl_next = lvl;
        rlist    = '0;
        do_idle  = 1'b0;
        done     = 1'b0;
        pr       = '0;
        fidx     = '0;
        term     = mht_pkg::is_space(in_byte) || in_byte == mht_pkg::CH_LPAR ||
                   in_byte == mht_pkg::CH_DQUOT ||
                   mht_pkg::special_char(in_byte, dot_special, eq_special);

        // per-mode handling of the byte
        case (st.mode)
            mht_pkg::MODE_ATOM: begin
                if (term) begin
                    rlist = push(rlist, mht_pkg::K_ATOM_END, 8'h00);
                    st_next.mode = mht_pkg::MODE_IDLE;
                    do_idle = 1'b1;
                end else begin
                    rlist = push(rlist, mht_pkg::K_TEXT, in_byte);
                end
            end
            mht_pkg::MODE_QSTR: begin
                // resolve a held cr first
                if (st.cr) begin
                    st_next.cr = 1'b0;
                    if (in_byte == mht_pkg::CH_LF) begin
                        done = 1'b1;
                        if (st_next.qp) begin
                            st_next.qp = 1'b0;
                            rlist = push(rlist, mht_pkg::K_TEXT, mht_pkg::CH_BSL);
                        end
                    end else begin
                        pr = qstr_plain(mht_pkg::CH_CR, st_next.qp);
                        if (pr.emit) begin
                            rlist = push(rlist, pr.kind, pr.value);
                        end
                        st_next.qp = pr.qp;
                        if (pr.close) begin
                            st_next.mode = mht_pkg::MODE_IDLE;
                        end
                    end
                end
                if (!done) begin
                    if (in_byte == mht_pkg::CH_CR) begin
                        st_next.cr = 1'b1;
                    end else begin
                        pr = qstr_plain(in_byte, st_next.qp);
                        if (pr.emit) begin
                            rlist = push(rlist, pr.kind, pr.value);
                        end
                        st_next.qp = pr.qp;
                        if (pr.close) begin
                            st_next.mode = mht_pkg::MODE_IDLE;
                        end
                    end
                end
            end
            default: begin
                st_next.mode = mht_pkg::MODE_IDLE;
                do_idle = 1'b1;
            end
        endcase

        // between tokens: comments, whitespace, specials, token starts
        if (do_idle) begin
            if (lvl != '0) begin
                if (st.esc) begin
                    st_next.esc = 1'b0;
                end else if (in_byte == mht_pkg::CH_BSL) begin
                    st_next.esc = 1'b1;
                end else if (in_byte == mht_pkg::CH_RPAR) begin
                    lvl_next = lvl - LVL_W'(1);
                end else if (in_byte == mht_pkg::CH_LPAR) begin
                    if (lvl < LVL_W'(MAX_DEPTH)) begin
                        lvl_next = lvl + LVL_W'(1);
                    end
                end
            end else if (in_byte == mht_pkg::CH_LPAR) begin
                lvl_next = LVL_W'(1);
            end else if (mht_pkg::is_space(in_byte)) begin
                lvl_next = lvl;
            end else if (mht_pkg::special_char(in_byte, dot_special, eq_special)) begin
                rlist = push(rlist, mht_pkg::K_SPECIAL, in_byte);
            end else if (in_byte == mht_pkg::CH_DQUOT) begin
                st_next.mode = mht_pkg::MODE_QSTR;
            end else begin
                rlist = push(rlist, mht_pkg::K_TEXT, in_byte);
                st_next.mode = mht_pkg::MODE_ATOM;
            end
        end

        // buffer end: close out, flag the last result, clear state
        if (last) begin
            case (st_next.mode)
                mht_pkg::MODE_ATOM: begin
                    rlist = push(rlist, mht_pkg::K_ATOM_END, 8'h00);
                    rlist = push(rlist, mht_pkg::K_END, 8'h00);
                end
                mht_pkg::MODE_QSTR: begin
                    if (st_next.cr) begin
                        pr = qstr_plain(mht_pkg::CH_CR, st_next.qp);
                        if (pr.emit) begin
                            rlist = push(rlist, pr.kind, pr.value);
                        end
                    end
                    rlist = push(rlist, mht_pkg::K_ERROR, 8'h00);
                end
                default: begin
                    if (lvl_next != '0) begin
                        rlist = push(rlist, mht_pkg::K_ERROR, 8'h00);
                    end else begin
                        rlist = push(rlist, mht_pkg::K_END, 8'h00);
                    end
                end
            endcase
            if (rlist.cnt != 3'd0) begin
                fidx = 2'(rlist.cnt - 3'd1);
                rlist.ent[fidx].final_res = 1'b1;
            end
            st_next  = '0;
            lvl_next = '0;
        end
    end

endmodule

// ===== design/mht_outbuf.sv =====
// result register: holds the results of one byte and hands them out one beat each
// depends on mht_pkg
module mht_outbuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  mht_pkg::res_list_t  rlist,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_kind,
    output logic [7:0]          m_value,
    output logic                m_final_res
);

    mht_pkg::res_list_t list_reg;
    logic [1:0]         idx_reg;
    logic               valid_reg;
    logic               at_last;
    logic               beat;

    assign at_last     = {1'b0, idx_reg} == (list_reg.cnt - 3'd1);
    assign beat        = valid_reg && m_ready;
    assign free        = !valid_reg || (m_ready && at_last);
    assign m_valid     = valid_reg;
    assign m_kind      = list_reg.ent[idx_reg].kind;
    assign m_value     = list_reg.ent[idx_reg].value;
    assign m_final_res = list_reg.ent[idx_reg].final_res;

    // control: load a new list or step through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (beat) begin
            if (at_last) begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            list_reg <= rlist;
        end
    end

endmodule
